>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)

`endif

`endif

>>> rtl/core/spq_pkg.sv
// types and codes of the sorted priority queue
package spq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } spq_ctrl_t;

endpackage

>>> rtl/core/spq_cell.sv
// one slot of the sorted chain: holds a pair, compares, shifts left or right
module spq_cell #(
  parameter int KEY_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spq_pkg::spq_ctrl_t         ctrl_i,
  input  logic signed [KEY_BITS-1:0] new_key_i,
  input  logic [7:0]                 new_elem_i,
  input  logic                       prev_cond_i,
  input  logic signed [KEY_BITS-1:0] left_key_i,
  input  logic [7:0]                 left_elem_i,
  input  logic                       left_valid_i,
  input  logic signed [KEY_BITS-1:0] right_key_i,
  input  logic [7:0]                 right_elem_i,
  input  logic                       right_valid_i,
  output logic signed [KEY_BITS-1:0] key_o,
  output logic [7:0]                 elem_o,
  output logic                       valid_o,
  output logic                       cond_o
);

  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [7:0]                 elem_q, elem_d;
  logic                       valid_q, valid_d;
  logic                       cond;

  // new word belongs at or before this slot
  assign cond = !valid_q || (new_key_i <= key_q);

  always_comb begin
    key_d   = key_q;
    elem_d  = elem_q;
    valid_d = valid_q;
    if (ctrl_i.ins_en) begin
      if (prev_cond_i) begin
        key_d   = left_key_i;
        elem_d  = left_elem_i;
        valid_d = left_valid_i;
      end else if (cond) begin
        key_d   = new_key_i;
        elem_d  = new_elem_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.rem_en) begin
      key_d   = right_key_i;
      elem_d  = right_elem_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    elem_q <= elem_d;
  end

  assign key_o   = key_q;
  assign elem_o  = elem_q;
  assign valid_o = valid_q;
  assign cond_o  = cond;

endmodule

>>> rtl/core/sorted_priority_queue.sv
// top level of the sorted priority queue
// Min-priority queue built as a row of CAPACITY slots kept in ascending key
// order, slot 0 holding the head. Every slot compares its key with the incoming
// key at once, so an insert or a remove-min completes for all slots together, and
// a new word is taken every cycle while the output is not stalled; the result
// word is registered and appears in the cycle after acceptance. The head fields,
// entry count and empty flag follow the slot registers and are valid together
// with out_valid_o. A stall on the output holds the input side until the pending
// result is taken. Among equal keys the most recently inserted pair is served
// first. Inserting into a full queue and removing from an empty one leave the
// contents untouched and are reported in status_o.
`include "assert_macros.svh"

module sorted_priority_queue #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic signed [KEY_BITS-1:0]           new_key_i,
  input  logic [7:0]                           new_element_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [KEY_BITS-1:0]           removed_key_o,
  output logic [7:0]                           removed_element_o,
  output logic signed [KEY_BITS-1:0]           head_key_o,
  output logic [7:0]                           head_element_o,
  output logic [$clog2(CAPACITY+1)-1:0]        entry_count_o,
  output logic                                 queue_empty_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic [7:0]                 cell_elem  [CAPACITY];
  logic [CAPACITY-1:0]        cell_valid;
  logic [CAPACITY-1:0]        cell_cond;

  logic                       accept;
  logic                       is_remove;
  logic                       full;
  logic                       empty;
  logic                       drop_ins;
  spq_pkg::spq_ctrl_t         ctrl;

  logic [CNT_W-1:0]           count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 status_q, status_d;
  logic signed [KEY_BITS-1:0] rem_key_q, rem_key_d;
  logic [7:0]                 rem_elem_q, rem_elem_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_remove  = (operation_i == spq_pkg::OP_REMOVE);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign drop_ins   = accept && !is_remove && full;

  assign ctrl.ins_en = accept && !is_remove && !full;
  assign ctrl.rem_en = accept && is_remove && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       prev_cond;
    logic signed [KEY_BITS-1:0] left_key, right_key;
    logic [7:0]                 left_elem, right_elem;
    logic                       left_valid, right_valid;

    if (i == 0) begin : g_first
      assign prev_cond  = 1'b0;
      assign left_key   = '0;
      assign left_elem  = '0;
      assign left_valid = 1'b0;
    end else begin : g_inner_left
      assign prev_cond  = cell_cond[i-1];
      assign left_key   = cell_key[i-1];
      assign left_elem  = cell_elem[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key   = '0;
      assign right_elem  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_key   = cell_key[i+1];
      assign right_elem  = cell_elem[i+1];
      assign right_valid = cell_valid[i+1];
    end

    spq_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_key_i    (new_key_i),
      .new_elem_i   (new_element_i),
      .prev_cond_i  (prev_cond),
      .left_key_i   (left_key),
      .left_elem_i  (left_elem),
      .left_valid_i (left_valid),
      .right_key_i  (right_key),
      .right_elem_i (right_elem),
      .right_valid_i(right_valid),
      .key_o        (cell_key[i]),
      .elem_o       (cell_elem[i]),
      .valid_o      (cell_valid[i]),
      .cond_o       (cell_cond[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    rem_key_d   = rem_key_q;
    rem_elem_d  = rem_elem_q;
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = spq_pkg::ST_DONE;
      rem_key_d   = '0;
      rem_elem_d  = '0;
      if (!is_remove) begin
        if (full) begin
          status_d = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = spq_pkg::ST_EMPTY;
        end else begin
          count_d    = count_q - CNT_W'(1);
          rem_key_d  = cell_key[0];
          rem_elem_d = cell_elem[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    rem_key_q  <= rem_key_d;
    rem_elem_q <= rem_elem_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign removed_key_o     = rem_key_q;
  assign removed_element_o = rem_elem_q;
  assign head_key_o        = cell_valid[0] ? cell_key[0] : '0;
  assign head_element_o    = cell_valid[0] ? cell_elem[0] : '0;
  assign entry_count_o     = count_q;
  assign queue_empty_o     = empty;

  // occupied slots always match the entry count
  `ASSERT_CLK(a_valid_count, $countones(cell_valid) == 32'(count_q))
  `ASSERT_NEVER(a_count_range, count_q > CNT_W'(CAPACITY))
  // a dropped insert leaves the count alone and reports full
  `ASSERT_CLK(a_full_drop, drop_ins |=> (status_q == spq_pkg::ST_FULL) && $stable(count_q))
  // the head slot is occupied exactly when the queue is not empty
  `ASSERT_CLK(a_head_valid, cell_valid[0] == !empty)

endmodule
